// ===== rtl/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg: shared types, widths and helpers for the triangle face normal block
// Widths of every pipeline stage follow from the constants at the top.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

    localparam int INDEX_BITS       = 16;
    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;

    localparam int FIELD_W  = 16;
    localparam int NORM_TOP = 29;

    localparam int EDGE_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * EDGE_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = CROSS_W;
    localparam int POS_W      = $clog2(MAG_W);
    localparam int SHF_W      = MAG_W + NORM_TOP;
    localparam int SCL_W      = NORM_TOP + 1;
    localparam int SQR_W      = 2 * SCL_W;
    localparam int SUM_W      = SQR_W + 2;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int LEN_W      = SQRT_STEPS;
    localparam int QUO_W      = NORMAL_FRAC_BITS + 1;
    localparam int DIV_W      = LEN_W + QUO_W + 1;

    localparam logic [FIELD_W-1:0] IDX_MASK = (INDEX_BITS >= FIELD_W) ?
        {FIELD_W{1'b1}} : FIELD_W'((64'd1 << INDEX_BITS) - 64'd1);

    typedef struct packed {
        logic [FIELD_W-1:0]        first_index;
        logic [FIELD_W-1:0]        second_index;
        logic [FIELD_W-1:0]        third_index;
        logic signed [FIELD_W-1:0] first_x;
        logic signed [FIELD_W-1:0] first_y;
        logic signed [FIELD_W-1:0] first_z;
        logic signed [FIELD_W-1:0] second_x;
        logic signed [FIELD_W-1:0] second_y;
        logic signed [FIELD_W-1:0] second_z;
        logic signed [FIELD_W-1:0] third_x;
        logic signed [FIELD_W-1:0] third_y;
        logic signed [FIELD_W-1:0] third_z;
    } tri_beat_t;

    typedef struct packed {
        logic [FIELD_W-1:0]        target_index;
        logic signed [FIELD_W-1:0] normal_x;
        logic signed [FIELD_W-1:0] normal_y;
        logic signed [FIELD_W-1:0] normal_z;
        logic                      degenerate;
        logic                      last_corner;
    } nrm_beat_t;

    typedef struct packed {
        logic [2:0][FIELD_W-1:0] index;
    } tri_idx_t;

    typedef struct packed {
        tri_idx_t                idx;
        logic [2:0][MAG_W-1:0]   mag;
        logic [2:0]              neg;
        logic                    deg;
    } mag_t;

    typedef struct packed {
        tri_idx_t                idx;
        logic [2:0][SCL_W-1:0]   mag;
        logic [2:0]              neg;
        logic                    deg;
    } scl_t;

    typedef struct packed {
        scl_t             s;
        logic [SUM_W-1:0] sum;
    } sum_t;

    typedef struct packed {
        scl_t             s;
        logic [LEN_W-1:0] len;
    } len_t;

    typedef struct packed {
        tri_idx_t                  idx;
        logic [2:0][FIELD_W-1:0]   normal;
        logic                      deg;
    } tri_res_t;

    // Position field to signed edge width: masked to COORD_BITS, sign-extended.
    function automatic logic signed [EDGE_W-1:0] coord_ext(input logic [FIELD_W-1:0] raw);
        logic signed [COORD_BITS-1:0] v;
        v = COORD_BITS'(raw);
        return EDGE_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/triangle_face_normal.sv =====
// ----------------------------------------------------------------------------
// Each triangle leaves as three corner beats, one per cycle while nrm_stall
// is low. The single result channel carries one triangle at a time; the pipeline
// itself takes a beat every cycle while tri_stall is low. Reset clears all
// valid bits and the corner counter; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

// ----------------------------------------------------------------------------
// triangle_face_normal: unit face normal per triangle, Q8.8 in, Q1.14 out
// Cross product, block normalize, square root, divide, three-beat output.
// ----------------------------------------------------------------------------
module triangle_face_normal
    import tfn_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      tri_valid,
    output logic           tri_stall,
    input  var  tri_beat_t tri_beat,
    output logic           nrm_valid,
    input  wire logic      nrm_stall,
    output nrm_beat_t      nrm_beat
);

    // Whole pipeline moves as one; it freezes only when the tail triangle
    // cannot go into the output register.
    logic     en;
    logic     cross_v, scale_v, sqrt_v, div_v, ser_ready;
    mag_t     cross_d;
    sum_t     scale_d;
    len_t     sqrt_d;
    tri_res_t div_d;

    assign en        = !div_v || ser_ready;
    assign tri_stall = !en;

    // edges, cross product, magnitudes
    tfn_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tri_valid),
        .in_data   (tri_beat),
        .out_valid (cross_v),
        .out_data  (cross_d)
    );

    // shift largest component to bit NORM_TOP, sum of squares
    tfn_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cross_v),
        .in_data   (cross_d),
        .out_valid (scale_v),
        .out_data  (scale_d)
    );

    // length = floor(sqrt(sum))
    tfn_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (scale_v),
        .in_data   (scale_d),
        .out_valid (sqrt_v),
        .out_data  (sqrt_d)
    );

    // rounded quotient, clamp to one, sign, zero on degenerate
    tfn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_v),
        .in_data   (sqrt_d),
        .out_valid (div_v),
        .out_data  (div_d)
    );

    // one beat per corner
    tfn_serial u_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_v),
        .in_data  (div_d),
        .in_ready (ser_ready),
        .valid    (nrm_valid),
        .stall    (nrm_stall),
        .beat     (nrm_beat)
    );

endmodule

`default_nettype wire

// ===== rtl/tfn_cross.sv =====
// ----------------------------------------------------------------------------
// tfn_cross: edge vectors, cross product and component magnitudes
// Four stages: edges, six products, differences, magnitude and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_cross
    import tfn_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  var  tri_beat_t in_data,
    output logic           out_valid,
    output mag_t           out_data
);

    logic                          v1_reg, v2_reg, v3_reg, v4_reg;
    tri_idx_t                      idx1_reg, idx2_reg, idx3_reg;
    logic signed [2:0][EDGE_W-1:0] e1_reg, e2_reg, e1_next, e2_next;
    logic signed [5:0][PROD_W-1:0] p_reg, p_next;
    logic signed [2:0][CROSS_W-1:0] c_reg, c_next;
    mag_t                          m_reg, m_next;
    tri_idx_t                      idx_next;

    always_comb
    begin
        idx_next.index[0] = in_data.first_index & IDX_MASK;
        idx_next.index[1] = in_data.second_index & IDX_MASK;
        idx_next.index[2] = in_data.third_index & IDX_MASK;
        e1_next[0] = coord_ext(in_data.second_x) - coord_ext(in_data.first_x);
        e1_next[1] = coord_ext(in_data.second_y) - coord_ext(in_data.first_y);
        e1_next[2] = coord_ext(in_data.second_z) - coord_ext(in_data.first_z);
        e2_next[0] = coord_ext(in_data.third_x) - coord_ext(in_data.first_x);
        e2_next[1] = coord_ext(in_data.third_y) - coord_ext(in_data.first_y);
        e2_next[2] = coord_ext(in_data.third_z) - coord_ext(in_data.first_z);
    end

    always_comb
    begin
        p_next[0] = PROD_W'($signed(e1_reg[1])) * PROD_W'($signed(e2_reg[2]));
        p_next[1] = PROD_W'($signed(e1_reg[2])) * PROD_W'($signed(e2_reg[1]));
        p_next[2] = PROD_W'($signed(e1_reg[2])) * PROD_W'($signed(e2_reg[0]));
        p_next[3] = PROD_W'($signed(e1_reg[0])) * PROD_W'($signed(e2_reg[2]));
        p_next[4] = PROD_W'($signed(e1_reg[0])) * PROD_W'($signed(e2_reg[1]));
        p_next[5] = PROD_W'($signed(e1_reg[1])) * PROD_W'($signed(e2_reg[0]));
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_next[i] = CROSS_W'($signed(p_reg[2*i])) - CROSS_W'($signed(p_reg[2*i+1]));
        end
    end

    always_comb
    begin
        m_next.idx = idx3_reg;
        for (int i = 0; i < 3; i++)
        begin
            m_next.neg[i] = c_reg[i][CROSS_W-1];
            m_next.mag[i] = c_reg[i][CROSS_W-1] ? MAG_W'(-c_reg[i]) : MAG_W'(c_reg[i]);
        end
        m_next.deg = (c_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg <= idx_next;
            e1_reg   <= e1_next;
            e2_reg   <= e2_next;
            idx2_reg <= idx1_reg;
            p_reg    <= p_next;
            idx3_reg <= idx2_reg;
            c_reg    <= c_next;
            m_reg    <= m_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = m_reg;

endmodule

`default_nettype wire

// ===== rtl/tfn_scale.sv =====
// ----------------------------------------------------------------------------
// tfn_scale: block normalization of the cross product and sum of squares
// Four stages: leading one, shift to bit NORM_TOP, squares, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_scale
    import tfn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  var  mag_t in_data,
    output logic      out_valid,
    output sum_t      out_data
);

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    mag_t                  m1_reg;
    logic [POS_W-1:0]      pos_reg, pos_next;
    scl_t                  s2_reg, s2_next, s3_reg;
    logic [2:0][SQR_W-1:0] sq_reg, sq_next;
    sum_t                  sum_reg, sum_next;
    logic [MAG_W-1:0]      any_bits;

    // MSB of the OR of all magnitudes is the MSB of the largest one
    always_comb
    begin
        any_bits = in_data.mag[0] | in_data.mag[1] | in_data.mag[2];
        pos_next = '0;
        for (int b = 0; b < MAG_W; b++)
        begin
            if (any_bits[b])
            begin
                pos_next = POS_W'(b);
            end
        end
    end

    // (mag << NORM_TOP) >> pos covers both the left and the right shift
    always_comb
    begin
        s2_next.idx = m1_reg.idx;
        s2_next.neg = m1_reg.neg;
        s2_next.deg = m1_reg.deg;
        for (int i = 0; i < 3; i++)
        begin
            s2_next.mag[i] = SCL_W'(({m1_reg.mag[i], {NORM_TOP{1'b0}}}) >> pos_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = SQR_W'(s2_reg.mag[i]) * SQR_W'(s2_reg.mag[i]);
        end
    end

    always_comb
    begin
        sum_next.s   = s3_reg;
        sum_next.sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg  <= in_data;
            pos_reg <= pos_next;
            s2_reg  <= s2_next;
            s3_reg  <= s2_reg;
            sq_reg  <= sq_next;
            sum_reg <= sum_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = sum_reg;

endmodule

`default_nettype wire

// ===== rtl/tfn_sqrt.sv =====
// ----------------------------------------------------------------------------
// tfn_sqrt: pipelined integer square root, one result bit per stage
// Digit-by-digit method; SQRT_STEPS stages, floor of the root.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_sqrt
    import tfn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  var  sum_t in_data,
    output logic      out_valid,
    output len_t      out_data
);

    typedef struct packed {
        scl_t             s;
        logic [SUM_W-1:0] x;
        logic [SUM_W-1:0] res;
    } sq_t;

    logic v_reg  [SQRT_STEPS];
    sq_t  st_reg [SQRT_STEPS];

    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_step
        localparam logic [SUM_W-1:0] STEP_BIT = SUM_W'(1) << (SUM_W - 2 - 2 * g);
        logic             cur_v;
        sq_t              cur, nxt;
        logic [SUM_W:0]   trial;

        if (g == 0)
        begin : g_first
            always_comb
            begin
                cur_v  = in_valid;
                cur.s  = in_data.s;
                cur.x  = in_data.sum;
                cur.res = '0;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                cur_v = v_reg[g-1];
                cur   = st_reg[g-1];
            end
        end

        always_comb
        begin
            nxt   = cur;
            trial = {1'b0, cur.res} + {1'b0, STEP_BIT};
            if ({1'b0, cur.x} >= trial)
            begin
                nxt.x   = SUM_W'({1'b0, cur.x} - trial);
                nxt.res = (cur.res >> 1) + STEP_BIT;
            end
            else
            begin
                nxt.res = cur.res >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= cur_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g] <= nxt;
            end
        end
    end

    assign out_valid    = v_reg[SQRT_STEPS-1];
    assign out_data.s   = st_reg[SQRT_STEPS-1].s;
    assign out_data.len = LEN_W'(st_reg[SQRT_STEPS-1].res);

endmodule

`default_nettype wire

// ===== rtl/tfn_div.sv =====
// ----------------------------------------------------------------------------
// tfn_div: rounded division of each scaled component by the length
// Restoring division, one quotient bit per stage, then clamp and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_div
    import tfn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  var  len_t in_data,
    output logic      out_valid,
    output tri_res_t  out_data
);

    typedef struct packed {
        tri_idx_t              idx;
        logic [2:0]            neg;
        logic                  deg;
        logic [LEN_W-1:0]      len;
        logic [2:0][DIV_W-1:0] rem;
        logic [2:0][QUO_W-1:0] q;
    } dv_t;

    localparam logic [QUO_W-1:0] Q_ONE = QUO_W'(1) << NORMAL_FRAC_BITS;

    logic     v_reg  [QUO_W];
    dv_t      st_reg [QUO_W];
    logic     fin_v_reg;
    tri_res_t fin_reg, fin_next;

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_step
        localparam int QB = QUO_W - 1 - g;
        logic             cur_v;
        dv_t              cur, nxt;
        logic [DIV_W-1:0] dsh;

        if (g == 0)
        begin : g_first
            always_comb
            begin
                cur_v   = in_valid;
                cur.idx = in_data.s.idx;
                cur.neg = in_data.s.neg;
                cur.deg = in_data.s.deg;
                cur.len = in_data.len;
                cur.q   = '0;
                for (int i = 0; i < 3; i++)
                begin
                    cur.rem[i] = (DIV_W'(in_data.s.mag[i]) << NORMAL_FRAC_BITS)
                               + DIV_W'(in_data.len >> 1);
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                cur_v = v_reg[g-1];
                cur   = st_reg[g-1];
            end
        end

        always_comb
        begin
            nxt = cur;
            dsh = DIV_W'(cur.len) << QB;
            for (int i = 0; i < 3; i++)
            begin
                if (cur.rem[i] >= dsh)
                begin
                    nxt.rem[i]   = cur.rem[i] - dsh;
                    nxt.q[i][QB] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= cur_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g] <= nxt;
            end
        end
    end

    always_comb
    begin
        logic [QUO_W-1:0] qc;
        logic [QUO_W:0]   sv;
        fin_next.idx = st_reg[QUO_W-1].idx;
        fin_next.deg = st_reg[QUO_W-1].deg;
        for (int i = 0; i < 3; i++)
        begin
            qc = (st_reg[QUO_W-1].q[i] > Q_ONE) ? Q_ONE : st_reg[QUO_W-1].q[i];
            sv = st_reg[QUO_W-1].neg[i] ? ((QUO_W+1)'(0) - {1'b0, qc}) : {1'b0, qc};
            fin_next.normal[i] = st_reg[QUO_W-1].deg ? '0 : FIELD_W'(sv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_v_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_v_reg <= v_reg[QUO_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_reg <= fin_next;
        end
    end

    assign out_valid = fin_v_reg;
    assign out_data  = fin_reg;

endmodule

`default_nettype wire

// ===== rtl/tfn_serial.sv =====
// ----------------------------------------------------------------------------
// tfn_serial: output register that sends one triangle as three beats
// Takes a new triangle when empty or while its last beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_serial
    import tfn_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  var  tri_res_t in_data,
    output logic          in_ready,
    output logic          valid,
    input  wire logic     stall,
    output nrm_beat_t     beat
);

    localparam logic [1:0] CORNER_FIRST  = 2'd0;
    localparam logic [1:0] CORNER_SECOND = 2'd1;
    localparam logic [1:0] CORNER_THIRD  = 2'd2;

    logic       full_reg, full_next;
    logic [1:0] cnt_reg, cnt_next;
    tri_res_t   hold_reg;
    logic       load;

    assign in_ready = !full_reg || (!stall && cnt_reg == CORNER_THIRD);
    assign load     = in_valid && in_ready;

    always_comb
    begin
        full_next = full_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            full_next = 1'b1;
            cnt_next  = CORNER_FIRST;
        end
        else if (full_reg && !stall)
        begin
            if (cnt_reg == CORNER_THIRD)
            begin
                full_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            cnt_reg  <= CORNER_FIRST;
        end
        else
        begin
            full_reg <= full_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= in_data;
        end
    end

    always_comb
    begin
        case (cnt_reg)
            CORNER_FIRST:  beat.target_index = hold_reg.idx.index[0];
            CORNER_SECOND: beat.target_index = hold_reg.idx.index[1];
            default:       beat.target_index = hold_reg.idx.index[2];
        endcase
        beat.normal_x    = hold_reg.normal[0];
        beat.normal_y    = hold_reg.normal[1];
        beat.normal_z    = hold_reg.normal[2];
        beat.degenerate  = hold_reg.deg;
        beat.last_corner = (cnt_reg == CORNER_THIRD);
    end

    assign valid = full_reg;

endmodule

`default_nettype wire
